/* design/opp_pkg.sv */
// Package for the operator precedence parser: widths, codes, microcode
// word layout and the structs passed between sequencer and datapath.
// No dependencies.
`default_nettype none

package opp_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int MAX_TERMINALS = 8;

  localparam int SYM_W   = 3;
  localparam int TC_W    = 4;
  localparam int ACT_W   = 3;
  localparam int DEPTH_W = 5;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int TBL_W   = 64;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  typedef enum logic [1:0] {
    REL_ERROR   = 2'd0,
    REL_LESS    = 2'd1,
    REL_EQUAL   = 2'd2,
    REL_GREATER = 2'd3
  } rel_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_SHIFT    = 3'd0,
    ACT_REDUCE   = 3'd1,
    ACT_ACCEPT   = 3'd2,
    ACT_REJECT   = 3'd3,
    ACT_OVERFLOW = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    REG_TERMINAL_COUNT = 2'd0,
    REG_END_MARKER     = 2'd1,
    REG_REL_LOW        = 2'd2,
    REG_REL_HIGH       = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    OP_LATCH = 3'd0,
    OP_CHECK = 3'd1,
    OP_RDTOP = 3'd2,
    OP_EVAL  = 3'd3,
    OP_SCAN  = 3'd4,
    OP_MARK  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_IN_VALID = 3'd1,
    C_BAD_IN   = 3'd2,
    C_FINAL    = 3'd3,
    C_POS_ZERO = 3'd4,
    C_MARK     = 3'd5
  } cond_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_CHECK = 3'd1,
    S_RDTOP = 3'd2,
    S_EVAL  = 3'd3,
    S_SCAN  = 3'd4,
    S_MARK  = 3'd5
  } step_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  emit;     // word produces a result item when its condition holds
    step_e on_true;
    step_e on_false;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic take;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad_in;
    logic final_v;
    logic pos_zero;
    logic mark;
    logic busy;
  } stat_t;

  typedef struct packed {
    logic [TC_W-1:0]  terminal_count;
    logic [SYM_W-1:0] end_marker;
    logic [TBL_W-1:0] rel_low;
    logic [TBL_W-1:0] rel_high;
  } cfg_t;

  typedef struct packed {
    logic             mark;
    logic [SYM_W-1:0] term;
  } entry_t;

endpackage

`default_nettype wire

/* design/opp_if.sv */
// Valid/ready channel interfaces for parser input and result items.
// Depends on opp_pkg.
`default_nettype none

interface opp_in_if;
  import opp_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             start_new;
  modport source (output valid, symbol, start_new, input ready);
  modport sink   (input valid, symbol, start_new, output ready);
endinterface

interface opp_out_if;
  import opp_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [DEPTH_W-1:0] depth_after;
  logic               last;
  modport source (output valid, action, depth_after, last, input ready);
  modport sink   (input valid, action, depth_after, last, output ready);
endinterface

`default_nettype wire

/* design/opp_regs.sv */
// APB-style configuration registers of the parser.
// Depends on opp_pkg.
`default_nettype none

module opp_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [opp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [opp_pkg::PDATA_W-1:0] pwdata,
  output logic      [opp_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output opp_pkg::cfg_t                    cfg_o
);
  import opp_pkg::*;

  logic [TC_W-1:0]  tc_q;
  logic [SYM_W-1:0] em_q;
  logic [TBL_W-1:0] lo_q, hi_q;
  logic             wr_en;
  reg_e             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_e'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TC_W'(MAX_TERMINALS);
      em_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TERMINAL_COUNT: tc_q <= pwdata[TC_W-1:0];
        REG_END_MARKER:     em_q <= pwdata[SYM_W-1:0];
        REG_REL_LOW:        lo_q <= pwdata[TBL_W-1:0];
        REG_REL_HIGH:       hi_q <= pwdata[TBL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TERMINAL_COUNT: prdata = PDATA_W'(tc_q);
      REG_END_MARKER:     prdata = PDATA_W'(em_q);
      REG_REL_LOW:        prdata = PDATA_W'(lo_q);
      REG_REL_HIGH:       prdata = PDATA_W'(hi_q);
    endcase
  end

  assign cfg_o = '{terminal_count: tc_q, end_marker: em_q, rel_low: lo_q, rel_high: hi_q};

endmodule

`default_nettype wire

/* design/opp_seq.sv */
// Microcode sequencer: program ROM, step counter, condition select and
// result-slot stall. Depends on opp_pkg.
`default_nettype none

module opp_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire opp_pkg::stat_t stat_i,
  output opp_pkg::ctrl_t      ctrl_o,
  output logic                in_ready_o
);
  import opp_pkg::*;

  step_e  step_q, step_d;
  ucode_t word;
  logic   cond_true;
  logic   stall;

  function automatic ucode_t ucode(input step_e s);
    ucode_t w;
    unique case (s)
      S_IDLE:  w = '{OP_LATCH, C_IN_VALID, 1'b0, S_CHECK, S_IDLE};
      S_CHECK: w = '{OP_CHECK, C_BAD_IN,   1'b1, S_IDLE,  S_RDTOP};
      S_RDTOP: w = '{OP_RDTOP, C_ALWAYS,   1'b0, S_EVAL,  S_EVAL};
      S_EVAL:  w = '{OP_EVAL,  C_FINAL,    1'b1, S_IDLE,  S_SCAN};
      S_SCAN:  w = '{OP_SCAN,  C_POS_ZERO, 1'b1, S_IDLE,  S_MARK};
      S_MARK:  w = '{OP_MARK,  C_MARK,     1'b1, S_RDTOP, S_SCAN};
      default: w = '{OP_LATCH, C_IN_VALID, 1'b0, S_CHECK, S_IDLE};
    endcase
    return w;
  endfunction

  assign word = ucode(step_q);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_IN_VALID: cond_true = stat_i.in_valid;
      C_BAD_IN:   cond_true = stat_i.bad_in;
      C_FINAL:    cond_true = stat_i.final_v;
      C_POS_ZERO: cond_true = stat_i.pos_zero;
      C_MARK:     cond_true = stat_i.mark;
      default:    cond_true = 1'b0;
    endcase
  end

  // hold the step while a result is due and the output slot is full and not being read
  assign stall  = word.emit && cond_true && stat_i.busy;
  assign step_d = stall ? step_q : (cond_true ? word.on_true : word.on_false);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o     = '{op: word.op, take: cond_true, fire: !stall};
  assign in_ready_o = (step_q == S_IDLE);

endmodule

`default_nettype wire

/* design/opp_dpath.sv */
// Parser datapath: stack memory, count and scan pointer, relation lookup,
// result register. Driven by the sequencer's control word. Depends on opp_pkg.
`default_nettype none

module opp_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire opp_pkg::cfg_t               cfg_i,
  input  wire opp_pkg::ctrl_t              ctrl_i,
  output opp_pkg::stat_t                   stat_o,
  input  wire logic                        in_valid_i,
  input  wire logic [opp_pkg::SYM_W-1:0]   in_symbol_i,
  input  wire logic                        in_start_new_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [opp_pkg::ACT_W-1:0]   out_action_o,
  output logic      [opp_pkg::DEPTH_W-1:0] out_depth_o,
  output logic                             out_last_o
);
  import opp_pkg::*;

  entry_t             mem [STACK_DEPTH];
  entry_t             rd_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d, pos_q, pos_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic               fin_q, fin_d;
  logic               ov_q;
  act_e               act_q;
  logic [DEPTH_W-1:0] dep_q;
  logic               last_q;

  logic               rd_en, wr_en;
  logic [SP_W-1:0]    rd_addr;
  entry_t             wr_data;
  logic               emit;
  act_e               emit_act;
  logic [CNT_W-1:0]   emit_depth;
  logic               emit_last;

  logic [TC_W-1:0]    limit;
  logic [SYM_W-1:0]   top_term;
  logic [5:0]         rel_idx;
  logic [TBL_W-1:0]   rel_word;
  rel_e               rel;
  logic               is_acc, full, final_v;
  act_e               eval_act;
  logic [CNT_W-1:0]   cnt_dec, pos_dec;

  assign limit    = (cfg_i.terminal_count > TC_W'(MAX_TERMINALS)) ?
                    TC_W'(MAX_TERMINALS) : cfg_i.terminal_count;
  assign top_term = (cnt_q == '0) ? cfg_i.end_marker : rd_q.term;
  assign rel_idx  = {top_term, sym_q};
  assign rel_word = rel_idx[5] ? cfg_i.rel_high : cfg_i.rel_low;
  assign rel      = (TC_W'(top_term) >= limit) ? REL_ERROR :
                    rel_e'(rel_word[{rel_idx[4:0], 1'b0} +: 2]);
  assign is_acc   = (top_term == cfg_i.end_marker) && (sym_q == cfg_i.end_marker);
  assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
  assign final_v  = is_acc || (rel != REL_GREATER);
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign pos_dec  = pos_q - CNT_W'(1);

  always_comb begin
    priority if (is_acc) begin
      eval_act = ACT_ACCEPT;
    end else if (rel == REL_LESS || rel == REL_EQUAL) begin
      eval_act = full ? ACT_OVERFLOW : ACT_SHIFT;
    end else begin
      eval_act = ACT_REJECT;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    sym_d      = sym_q;
    fin_d      = fin_q;
    rd_en      = 1'b0;
    rd_addr    = cnt_dec[SP_W-1:0];
    wr_en      = 1'b0;
    wr_data    = '{mark: (rel == REL_LESS), term: sym_q};
    emit       = 1'b0;
    emit_act   = ACT_REJECT;
    emit_depth = cnt_q;
    emit_last  = 1'b1;
    unique case (ctrl_i.op)
      OP_LATCH: begin
        if (ctrl_i.fire && ctrl_i.take) begin
          sym_d = in_symbol_i;
          if (in_start_new_i) begin
            cnt_d = '0;
            fin_d = 1'b0;
          end
        end
      end
      OP_CHECK: begin
        if (ctrl_i.fire && ctrl_i.take) begin
          fin_d = 1'b1;
          emit  = 1'b1;
        end
      end
      OP_RDTOP: begin
        rd_en = ctrl_i.fire;
      end
      OP_EVAL: begin
        if (ctrl_i.fire) begin
          if (ctrl_i.take) begin
            emit     = 1'b1;
            emit_act = eval_act;
            if (eval_act == ACT_SHIFT) begin
              wr_en      = 1'b1;
              cnt_d      = cnt_q + CNT_W'(1);
              emit_depth = cnt_q + CNT_W'(1);
            end else begin
              fin_d = 1'b1;
            end
          end else begin
            pos_d = cnt_q;
          end
        end
      end
      OP_SCAN: begin
        if (ctrl_i.fire) begin
          if (ctrl_i.take) begin
            fin_d = 1'b1;
            emit  = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_dec[SP_W-1:0];
            pos_d   = pos_dec;
          end
        end
      end
      OP_MARK: begin
        if (ctrl_i.fire && ctrl_i.take) begin
          cnt_d      = pos_q;
          emit       = 1'b1;
          emit_act   = ACT_REDUCE;
          emit_depth = pos_q;
          emit_last  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[SP_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      fin_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      fin_q <= fin_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    if (emit) begin
      act_q  <= emit_act;
      dep_q  <= DEPTH_W'(emit_depth);
      last_q <= emit_last;
    end
  end

  assign stat_o = '{in_valid: in_valid_i,
                    bad_in:   fin_q || (TC_W'(sym_q) >= limit),
                    final_v:  final_v,
                    pos_zero: (pos_q == '0),
                    mark:     rd_q.mark,
                    busy:     ov_q && !out_ready_i};

  assign out_valid_o  = ov_q;
  assign out_action_o = act_q;
  assign out_depth_o  = dep_q;
  assign out_last_o   = last_q;

endmodule

`default_nettype wire

/* design/operator_precedence_parser.sv */
// Top level of the operator precedence parser: configuration registers,
// microcode sequencer and datapath. Depends on opp_pkg, opp_if, opp_regs,
// opp_seq and opp_dpath.
//
// Shift-reduce parser over up to 8 terminals with a 16-entry stack. Each
// input item is one terminal index; it yields zero or more reduce items
// (last = 0) and then one shift, accept, reject or overflow item (last = 1).
// Items are handled one at a time under a six-step microprogram. A symbol
// settled by its first table lookup (shift, accept, overflow or a reject on
// an error relation) passes through the latch, check, read-top and eval
// steps, its result loading from the eval step; an out-of-range symbol, or
// one ignored after the parse has finished, passes through latch and check
// alone. Each reduce scans the stack, reading one entry in a scan step and
// testing its less mark in a mark step, then rereads the new stack top and
// evaluates again; a scan that reaches the bottom without a mark rejects.
// The next item is accepted as soon as the last result is in the output
// register, and the sequencer stalls only while a result is due and that
// register is full and not being read out.
// Registers: terminal_count at 0x00, end_marker at 0x08, relation table low
// word at 0x10 and high word at 0x18, 64-bit data; write only while idle.
`default_nettype none

module operator_precedence_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [opp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [opp_pkg::PDATA_W-1:0] pwdata,
  output logic      [opp_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  opp_in_if.sink                           in_i,
  opp_out_if.source                        out_o
);
  import opp_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  opp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  opp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (in_i.ready)
  );

  opp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .in_valid_i     (in_i.valid),
    .in_symbol_i    (in_i.symbol),
    .in_start_new_i (in_i.start_new),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_action_o   (out_o.action),
    .out_depth_o    (out_o.depth_after),
    .out_last_o     (out_o.last)
  );

endmodule

`default_nettype wire

/* tb/opp_tb_pkg.sv */
// Scoreboard for the operator precedence parser testbench: predicts the
// result items of every accepted symbol and checks the DUT results in order.
// Depends on opp_pkg.
package opp_tb_pkg;
  import opp_pkg::*;

  typedef struct packed {
    act_e               action;
    logic [DEPTH_W-1:0] depth_after;
    logic               last;
  } parse_result_t;

  class parse_scoreboard;
    logic [TC_W-1:0]    term_count;
    logic [SYM_W-1:0]   end_sym;
    logic [2*TBL_W-1:0] rel_table;
    logic [SYM_W-1:0]   stack_term [STACK_DEPTH];
    bit                 stack_mark [STACK_DEPTH];
    int unsigned        depth;
    bit                 done;
    parse_result_t      expected_q [$];
    int                 errors;

    function new();
      term_count = TC_W'(MAX_TERMINALS);
      end_sym    = '0;
      rel_table  = '0;
      depth      = 0;
      done       = 0;
      errors     = 0;
    endfunction

    function void set_reg(reg_e idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_TERMINAL_COUNT: term_count = value[TC_W-1:0];
        REG_END_MARKER:     end_sym = value[SYM_W-1:0];
        REG_REL_LOW:        rel_table[TBL_W-1:0] = value[TBL_W-1:0];
        REG_REL_HIGH:       rel_table[2*TBL_W-1:TBL_W] = value[TBL_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_result(act_e action, bit last);
      parse_result_t r;
      r.action      = action;
      r.depth_after = DEPTH_W'(depth);
      r.last        = last;
      expected_q.push_back(r);
    endfunction

    function rel_e lookup(logic [SYM_W-1:0] top, logic [SYM_W-1:0] sym);
      int idx;
      idx = 16 * int'(top) + 2 * int'(sym);
      return rel_e'(rel_table[idx +: 2]);
    endfunction

    // Runs the shift-reduce step for one symbol and queues its results.
    function void note_input(logic [SYM_W-1:0] sym, logic start_new);
      int unsigned      lim;
      logic [SYM_W-1:0] top;
      rel_e             rel;
      int               pos;
      bit               found;
      bit               more;
      lim = (term_count > MAX_TERMINALS) ? MAX_TERMINALS : term_count;
      if (start_new) begin
        depth = 0;
        done  = 0;
      end
      if (done) begin
        push_result(ACT_REJECT, 1'b1);
        return;
      end
      if (sym >= lim) begin
        done = 1;
        push_result(ACT_REJECT, 1'b1);
        return;
      end
      more = 1;
      while (more) begin
        top = (depth == 0) ? end_sym : stack_term[depth-1];
        if (top == end_sym && sym == end_sym) begin
          done = 1;
          more = 0;
          push_result(ACT_ACCEPT, 1'b1);
        end else begin
          rel = (top >= lim) ? REL_ERROR : lookup(top, sym);
          if (rel == REL_LESS || rel == REL_EQUAL) begin
            more = 0;
            if (depth >= STACK_DEPTH) begin
              done = 1;
              push_result(ACT_OVERFLOW, 1'b1);
            end else begin
              stack_term[depth] = sym;
              stack_mark[depth] = (rel == REL_LESS);
              depth++;
              push_result(ACT_SHIFT, 1'b1);
            end
          end else if (rel == REL_GREATER) begin
            pos   = depth;
            found = 0;
            while (pos > 0 && !found) begin
              pos--;
              found = stack_mark[pos];
            end
            if (!found) begin
              done = 1;
              more = 0;
              push_result(ACT_REJECT, 1'b1);
            end else begin
              depth = pos;
              push_result(ACT_REDUCE, 1'b0);
            end
          end else begin
            done = 1;
            more = 0;
            push_result(ACT_REJECT, 1'b1);
          end
        end
      end
    endfunction

    function void check(logic [ACT_W-1:0] action, logic [DEPTH_W-1:0] depth_after,
                        logic last);
      parse_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: action %0d depth_after %0d last %0d",
               action, depth_after, last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (action !== exp_r.action) begin
        $error("action: expected %0d, got %0d", exp_r.action, action);
        errors++;
      end
      if (depth_after !== exp_r.depth_after) begin
        $error("depth_after: expected %0d, got %0d", exp_r.depth_after, depth_after);
        errors++;
      end
      if (last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/operator_precedence_parser_test.sv */
// Top of the operator precedence parser testbench: clock, reset, APB
// register writes, symbol stimulus and result monitor.
// Depends on opp_pkg, opp_if, opp_tb_pkg and the parser RTL.
module operator_precedence_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import opp_pkg::*;
  import opp_tb_pkg::*;

  localparam int LIMIT = 500000;

  typedef enum int {TOK_END, TOK_ID, TOK_PLUS, TOK_STAR, TOK_OPEN, TOK_CLOSE} token_e;

  localparam rel_e ER = REL_ERROR;
  localparam rel_e LT = REL_LESS;
  localparam rel_e EQ = REL_EQUAL;
  localparam rel_e GT = REL_GREATER;

  // rows: stack top, columns: input; order $ id + * ( )
  localparam rel_e GRAMMAR [6][6] = '{
    '{ER, LT, LT, LT, LT, ER},
    '{GT, ER, GT, GT, ER, GT},
    '{GT, LT, GT, LT, LT, GT},
    '{GT, LT, GT, GT, LT, GT},
    '{ER, LT, LT, LT, LT, EQ},
    '{GT, ER, GT, GT, ER, GT}
  };

  localparam logic [5:0][SYM_W-1:0] IDENT_MAP = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  localparam logic [SYM_W-1:0] CH_END = 3'd0;
  localparam logic [SYM_W-1:0] CH_A   = 3'd1;
  localparam logic [SYM_W-1:0] CH_B   = 3'd2;
  localparam logic [SYM_W-1:0] CH_C   = 3'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  opp_in_if  in_bus ();
  opp_out_if out_bus ();

  operator_precedence_parser uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  parse_scoreboard sb;
  int              items_sent = 0;
  bit              calm = 0;
  int              cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check(out_bus.action, out_bus.depth_after, out_bus.last);
    end
  end

  // result side back-pressure, with one long hold-off early in the run
  initial begin
    int stall_left;
    bit squeezed;
    stall_left = 0;
    squeezed   = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!squeezed && items_sent >= 40) begin
        squeezed   = 1;
        stall_left = 300;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic [2*TBL_W-1:0] with_rel(logic [2*TBL_W-1:0] t,
                                                  logic [SYM_W-1:0] top,
                                                  logic [SYM_W-1:0] sym, rel_e r);
    int idx;
    idx = 16 * int'(top) + 2 * int'(sym);
    t[idx +: 2] = r;
    return t;
  endfunction

  function automatic logic [2*TBL_W-1:0] grammar_table(logic [5:0][SYM_W-1:0] m);
    logic [2*TBL_W-1:0] t;
    t = {$urandom, $urandom, $urandom, $urandom};
    for (int a = 0; a < 6; a++) begin
      for (int b = 0; b < 6; b++) begin
        t = with_rel(t, m[a], m[b], GRAMMAR[a][b]);
      end
    end
    return t;
  endfunction

  // a-run then b: every a reduces singly, so 16 a's give 16 reduces
  function automatic logic [2*TBL_W-1:0] chain_table();
    logic [2*TBL_W-1:0] t;
    t = '0;
    t = with_rel(t, CH_A, CH_A, LT);
    t = with_rel(t, CH_A, CH_B, GT);
    t = with_rel(t, CH_A, CH_END, GT);
    t = with_rel(t, CH_END, CH_A, LT);
    t = with_rel(t, CH_END, CH_B, LT);
    t = with_rel(t, CH_END, CH_C, EQ);
    t = with_rel(t, CH_B, CH_A, LT);
    t = with_rel(t, CH_B, CH_B, GT);
    t = with_rel(t, CH_B, CH_END, GT);
    t = with_rel(t, CH_C, CH_B, GT);
    t = with_rel(t, CH_C, CH_END, GT);
    return t;
  endfunction

  task automatic write_reg(input reg_e idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic configure(input logic [TC_W-1:0] tc, input logic [SYM_W-1:0] end_sym,
                           input logic [2*TBL_W-1:0] tbl);
    wait_idle();
    write_reg(REG_TERMINAL_COUNT, PDATA_W'(tc));
    write_reg(REG_END_MARKER, PDATA_W'(end_sym));
    write_reg(REG_REL_LOW, tbl[TBL_W-1:0]);
    write_reg(REG_REL_HIGH, tbl[2*TBL_W-1:TBL_W]);
  endtask

  task automatic send_item(input logic [SYM_W-1:0] sym, input logic start_new);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.symbol    <= sym;
    in_bus.start_new <= start_new;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_input(sym, start_new);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(SYM_W'($urandom_range(0, 7)), $urandom_range(0, 2) == 0);
  endtask

  // random well-formed expression, optionally with one symbol spoiled
  task automatic send_expression(input logic [5:0][SYM_W-1:0] m, input bit corrupt);
    logic [SYM_W-1:0] syms [$];
    int               open_cnt;
    bit               want_operand;
    bit               closed;
    open_cnt     = 0;
    want_operand = 1;
    closed       = 0;
    while (!closed) begin
      if (want_operand) begin
        if (open_cnt < 3 && syms.size() < 12 && $urandom_range(0, 3) == 0) begin
          syms.push_back(m[TOK_OPEN]);
          open_cnt++;
        end else begin
          syms.push_back(m[TOK_ID]);
          want_operand = 0;
        end
      end else if (open_cnt == 0 && (syms.size() >= 12 || $urandom_range(0, 3) == 0)) begin
        closed = 1;
      end else if (open_cnt > 0 && (syms.size() >= 12 || $urandom_range(0, 2) == 0)) begin
        syms.push_back(m[TOK_CLOSE]);
        open_cnt--;
      end else begin
        syms.push_back($urandom_range(0, 1) ? m[TOK_PLUS] : m[TOK_STAR]);
        want_operand = 1;
      end
    end
    syms.push_back(m[TOK_END]);
    if (corrupt) syms[$urandom_range(0, syms.size() - 1)] = SYM_W'($urandom_range(0, 7));
    foreach (syms[i]) send_item(syms[i], i == 0);
  endtask

  task automatic run_grammar(input logic [5:0][SYM_W-1:0] m, input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        send_expression(m, $urandom_range(0, 5) == 0);
      end
    end
  endtask

  task automatic send_chain();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 17) : $urandom_range(0, 15);
    for (int i = 0; i < n; i++) send_item(CH_A, i == 0);
    send_item(($urandom_range(0, 4) == 0) ? CH_C : CH_B, n == 0);
    if ($urandom_range(0, 3) == 0) send_noise();
    send_item(CH_END, 1'b0);
  endtask

  initial begin
    logic [5:0][SYM_W-1:0] perm_map;
    int                    perm [8];
    int                    j;
    int                    tmp;
    sb = new();
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.symbol    <= '0;
    in_bus.start_new <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all-error table, end marker 0
    send_item(3'd0, 1'b1);
    send_item(3'd0, 1'b0);
    send_item(3'd5, 1'b1);
    send_item(3'd7, 1'b1);

    // longest reduce chain, reduce without a less mark, out-of-range symbol
    configure(4'd4, CH_END, chain_table());
    for (int i = 0; i < 16; i++) send_item(CH_A, i == 0);
    send_item(CH_B, 1'b0);
    send_item(CH_C, 1'b1);
    send_item(CH_B, 1'b0);
    send_item(3'd4, 1'b1);
    send_item(CH_A, 1'b1);
    send_item(CH_A, 1'b0);

    // stack top left out of range by a lower terminal count
    wait_idle();
    write_reg(REG_TERMINAL_COUNT, PDATA_W'(1));
    send_item(3'd0, 1'b0);

    configure(4'd6, 3'd0, grammar_table(IDENT_MAP));
    run_grammar(IDENT_MAP, 140);

    configure(4'd4, CH_END, chain_table());
    while (items_sent < 215) send_chain();

    configure(4'd15, 3'd7, {2*TBL_W{1'b1}});
    repeat (15) send_noise();

    configure(4'd0, SYM_W'($urandom_range(0, 7)), {$urandom, $urandom, $urandom, $urandom});
    repeat (5) send_noise();

    configure(TC_W'($urandom_range(1, 8)), SYM_W'($urandom_range(0, 7)),
              {$urandom, $urandom, $urandom, $urandom});
    repeat (20) send_noise();

    for (int i = 0; i < 8; i++) perm[i] = i;
    for (int i = 7; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < 6; i++) perm_map[i] = SYM_W'(perm[i]);
    configure($urandom_range(0, 1) ? 4'd15 : 4'd8, perm_map[TOK_END], grammar_table(perm_map));
    run_grammar(perm_map, 330);

    calm = 1;
    run_grammar(perm_map, 385);

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
